[src/upr_pkg.sv]
// Shared types, constants and the CRC helper for the update packet receiver.
package upr_pkg;

    localparam int BLOCK_BYTES_DEF = 1024;
    localparam int IMAGE_BYTES_DEF = 65536;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] SYNC_BYTE     = 8'hAA;
    localparam logic [7:0] FOOTER_BYTE   = 8'h55;
    localparam logic [7:0] CMD_PING      = 8'h42;
    localparam logic [7:0] CMD_FW_REV    = 8'h0A;
    localparam logic [7:0] CMD_HW_ID     = 8'h02;
    localparam logic [7:0] CMD_COUNT     = 8'h04;
    localparam logic [7:0] CMD_BLOCK     = 8'h03;
    localparam logic [7:0] CMD_END       = 8'h45;
    localparam logic [7:0] RES_ACK       = 8'h06;
    localparam logic [7:0] RES_LEN_ERR   = 8'hE1;
    localparam logic [7:0] RES_FLASH_ERR = 8'hE3;
    localparam logic [7:0] RES_UNKNOWN   = 8'hE5;

    localparam logic [1:0] OP_RX_BYTE = 2'd0;
    localparam logic [1:0] OP_TIMEOUT = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    localparam logic [1:0] KIND_REPLY = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  rx_byte;
        logic [15:0] read_address;
    } upr_in_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  reply_byte;
        logic        reply_last;
        logic [7:0]  read_data;
        logic [16:0] image_length;
    } upr_out_t;

    typedef enum logic [3:0] {
        PH_HUNT,
        PH_HDR0,
        PH_HDR1,
        PH_HDR2,
        PH_HDR3,
        PH_HDR4,
        PH_PAYLOAD,
        PH_CRCHI,
        PH_CRCLO,
        PH_FOOTER
    } phase_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_WAIT,
        ST_SEND_DONE,
        ST_SETUP,
        ST_KEY_RD,
        ST_KEY_WR,
        ST_XF_RD,
        ST_XF_WR,
        ST_REPLY_CRC,
        ST_REPLY
    } state_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[src/update_packet_receiver_top.sv]
// Top level of the update packet receiver: frame parser, block commit and reply sender.
// After reset the block sweeps both stores to zero, one address per cycle, and takes no
// transaction meanwhile. A footer with a good CRC passes through a setup state that
// decodes the command, after which a key load and a data block each read the packet RAM
// byte by byte through its single read port. Every reply runs its CRC over five bytes
// and is followed by nine output transactions. A finished result waits in an output
// register, so a new transaction is taken while it is pending.
module update_packet_receiver_top #(
    parameter int BLOCK_BYTES = upr_pkg::BLOCK_BYTES_DEF,
    parameter int IMAGE_BYTES = upr_pkg::IMAGE_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  upr_pkg::upr_in_t item,
    output logic             result_valid,
    input  logic             result_ready,
    output upr_pkg::upr_out_t result
);

    localparam int PW = $clog2(BLOCK_BYTES);
    localparam int IW = $clog2(IMAGE_BYTES);
    localparam int CW = $clog2(BLOCK_BYTES + 1);
    localparam int HW = $clog2(IMAGE_BYTES + 1);

    upr_pkg::state_t   state_reg, state_next;
    upr_pkg::phase_t   phase_reg, phase_next;
    logic [7:0]        hdr_reg [5];
    logic [7:0]        hdr_next [5];
    logic [CW-1:0]     count_reg, count_next;
    logic [15:0]       crc_reg, crc_next;
    logic [7:0]        crc_hi_reg, crc_hi_next;
    logic [7:0]        crc_lo_reg, crc_lo_next;
    logic [7:0]        key_reg [16];
    logic [7:0]        key_next [16];
    logic              key_valid_reg, key_valid_next;
    logic [HW-1:0]     hw_reg, hw_next;
    logic              done_reg, done_next;
    logic [IW-1:0]     clr_reg, clr_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [31:0]       off_reg, off_next;
    logic              dec_reg, dec_next;
    logic [7:0]        res_reg, res_next;
    logic [15:0]       rcrc_reg, rcrc_next;
    logic [3:0]        rpos_reg, rpos_next;
    logic              oor_reg, oor_next;
    logic              out_valid_reg, out_valid_next;
    upr_pkg::upr_out_t out_reg, out_next;

    logic          pkt_we;
    logic [PW-1:0] pkt_waddr;
    logic [7:0]    pkt_wdata;
    logic          pkt_re;
    logic [PW-1:0] pkt_raddr;
    logic [7:0]    pkt_rdata;
    logic          img_we;
    logic [IW-1:0] img_waddr;
    logic [7:0]    img_wdata;
    logic          img_re;
    logic [IW-1:0] img_raddr;
    logic [7:0]    img_rdata;

    upr_ram #(.DEPTH(BLOCK_BYTES), .AW(PW)) u_pkt_ram (
        .clk   (clk),
        .we    (pkt_we),
        .waddr (pkt_waddr),
        .wdata (pkt_wdata),
        .re    (pkt_re),
        .raddr (pkt_raddr),
        .rdata (pkt_rdata)
    );

    upr_ram #(.DEPTH(IMAGE_BYTES), .AW(IW)) u_img_ram (
        .clk   (clk),
        .we    (img_we),
        .waddr (img_waddr),
        .wdata (img_wdata),
        .re    (img_re),
        .raddr (img_raddr),
        .rdata (img_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= upr_pkg::ST_CLEAR;
            phase_reg     <= upr_pkg::PH_HUNT;
            count_reg     <= '0;
            crc_reg       <= '0;
            key_valid_reg <= 1'b0;
            hw_reg        <= '0;
            done_reg      <= 1'b0;
            clr_reg       <= '0;
            idx_reg       <= '0;
            rpos_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 5; i++)
            begin
                hdr_reg[i] <= '0;
            end
            for (int i = 0; i < 16; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            crc_reg       <= crc_next;
            key_valid_reg <= key_valid_next;
            hw_reg        <= hw_next;
            done_reg      <= done_next;
            clr_reg       <= clr_next;
            idx_reg       <= idx_next;
            rpos_reg      <= rpos_next;
            out_valid_reg <= out_valid_next;
            hdr_reg       <= hdr_next;
            key_reg       <= key_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_hi_reg <= crc_hi_next;
        crc_lo_reg <= crc_lo_next;
        off_reg    <= off_next;
        dec_reg    <= dec_next;
        res_reg    <= res_next;
        rcrc_reg   <= rcrc_next;
        oor_reg    <= oor_next;
        out_reg    <= out_next;
    end

    always_comb
    begin
        logic        accept;
        logic        out_free;
        logic [7:0]  cmd;
        logic [15:0] args;
        logic [15:0] dlen;
        logic [15:0] new_dlen;
        logic [2:0]  hdr_idx;
        logic [31:0] ext_addr;
        logic [31:0] sum;
        logic        ovf;
        logic [6:0]  kidx;
        logic [7:0]  kb;
        logic [15:0] kdbl;
        logic [15:0] krot;
        logic [7:0]  ek;
        logic [7:0]  xb;
        logic [7:0]  nb;
        logic [7:0]  rbyte;
        logic [31:0] hp1;

        state_next     = state_reg;
        phase_next     = phase_reg;
        hdr_next       = hdr_reg;
        count_next     = count_reg;
        crc_next       = crc_reg;
        crc_hi_next    = crc_hi_reg;
        crc_lo_next    = crc_lo_reg;
        key_next       = key_reg;
        key_valid_next = key_valid_reg;
        hw_next        = hw_reg;
        done_next      = done_reg;
        clr_next       = clr_reg;
        idx_next       = idx_reg;
        off_next       = off_reg;
        dec_next       = dec_reg;
        res_next       = res_reg;
        rcrc_next      = rcrc_reg;
        rpos_next      = rpos_reg;
        oor_next       = oor_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result_ready;

        pkt_we    = 1'b0;
        pkt_waddr = '0;
        pkt_wdata = '0;
        pkt_re    = 1'b0;
        pkt_raddr = idx_reg[PW-1:0];
        img_we    = 1'b0;
        img_waddr = '0;
        img_wdata = '0;
        img_re    = 1'b0;

        item_ready = (state_reg == upr_pkg::ST_IDLE);
        accept     = item_valid && item_ready;
        out_free   = !out_valid_reg || result_ready;

        cmd      = hdr_reg[0];
        args     = {hdr_reg[1], hdr_reg[2]};
        dlen     = {hdr_reg[3], hdr_reg[4]};
        new_dlen = {hdr_reg[3], item.rx_byte};
        hdr_idx  = 3'(4'(phase_reg) - 4'(upr_pkg::PH_HDR1) + 4'd1);
        ext_addr = 32'(item.read_address);
        img_raddr = ext_addr[IW-1:0];

        sum = off_reg + 32'(dlen);
        ovf = sum > 32'(IMAGE_BYTES);

        kidx = off_reg[6:0] + 7'(BLOCK_BYTES) + idx_reg[6:0];
        kb   = key_reg[kidx[3:0]];
        kdbl = {kb, kb};
        krot = kidx[3] ? (kdbl >> kidx[6:4]) : (kdbl << kidx[6:4]);
        ek   = kidx[3] ? krot[7:0] : krot[15:8];
        xb   = pkt_rdata ^ ek;
        if (!dec_reg || pkt_rdata == 8'h00 || pkt_rdata == 8'hFF || xb == 8'h00 || xb == 8'hFF)
        begin
            nb = pkt_rdata;
        end
        else
        begin
            nb = xb;
        end

        if (rpos_reg == 4'd0)
        begin
            rbyte = cmd;
        end
        else if (rpos_reg == 4'd2)
        begin
            rbyte = res_reg;
        end
        else
        begin
            rbyte = 8'h00;
        end

        hp1 = 32'(hw_reg) + 32'd1;

        if (state_reg != upr_pkg::ST_REPLY_CRC && state_reg != upr_pkg::ST_REPLY)
        begin
            rcrc_next = '0;
            rpos_next = '0;
        end

        unique case (state_reg)
            upr_pkg::ST_CLEAR:
            begin
                img_we    = 1'b1;
                img_waddr = clr_reg;
                if (32'(clr_reg) < 32'(BLOCK_BYTES))
                begin
                    pkt_we    = 1'b1;
                    pkt_waddr = clr_reg[PW-1:0];
                end
                if (32'(clr_reg) == 32'(IMAGE_BYTES - 1))
                begin
                    state_next = upr_pkg::ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + IW'(1);
                end
            end

            upr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.opcode == upr_pkg::OP_READ)
                    begin
                        img_re     = 1'b1;
                        oor_next   = !(ext_addr < 32'(IMAGE_BYTES));
                        state_next = upr_pkg::ST_READ_WAIT;
                    end
                    else if (item.opcode == upr_pkg::OP_TIMEOUT && !done_reg)
                    begin
                        done_next  = 1'b1;
                        state_next = upr_pkg::ST_SEND_DONE;
                    end
                    else if (item.opcode == upr_pkg::OP_RX_BYTE && !done_reg)
                    begin
                        unique case (phase_reg)
                            upr_pkg::PH_HUNT:
                            begin
                                if (item.rx_byte == upr_pkg::SYNC_BYTE)
                                begin
                                    phase_next = upr_pkg::PH_HDR0;
                                    crc_next   = '0;
                                    count_next = '0;
                                end
                            end
                            upr_pkg::PH_HDR0, upr_pkg::PH_HDR1, upr_pkg::PH_HDR2,
                            upr_pkg::PH_HDR3:
                            begin
                                hdr_next[hdr_idx] = item.rx_byte;
                                crc_next   = upr_pkg::crc_byte(crc_reg, item.rx_byte);
                                phase_next = upr_pkg::phase_t'(4'(phase_reg) + 4'd1);
                            end
                            upr_pkg::PH_HDR4:
                            begin
                                hdr_next[4] = item.rx_byte;
                                crc_next    = upr_pkg::crc_byte(crc_reg, item.rx_byte);
                                count_next  = '0;
                                if (32'(new_dlen) > 32'(BLOCK_BYTES))
                                begin
                                    phase_next = upr_pkg::PH_HUNT;
                                    res_next   = upr_pkg::RES_LEN_ERR;
                                    state_next = upr_pkg::ST_REPLY_CRC;
                                end
                                else if (new_dlen == 16'd0)
                                begin
                                    phase_next = upr_pkg::PH_CRCHI;
                                end
                                else
                                begin
                                    phase_next = upr_pkg::PH_PAYLOAD;
                                end
                            end
                            upr_pkg::PH_PAYLOAD:
                            begin
                                pkt_we     = 1'b1;
                                pkt_waddr  = count_reg[PW-1:0];
                                pkt_wdata  = item.rx_byte;
                                crc_next   = upr_pkg::crc_byte(crc_reg, item.rx_byte);
                                count_next = count_reg + CW'(1);
                                if (16'(count_reg + CW'(1)) >= dlen)
                                begin
                                    phase_next = upr_pkg::PH_CRCHI;
                                end
                            end
                            upr_pkg::PH_CRCHI:
                            begin
                                crc_hi_next = item.rx_byte;
                                phase_next  = upr_pkg::PH_CRCLO;
                            end
                            upr_pkg::PH_CRCLO:
                            begin
                                crc_lo_next = item.rx_byte;
                                phase_next  = upr_pkg::PH_FOOTER;
                            end
                            upr_pkg::PH_FOOTER:
                            begin
                                phase_next = upr_pkg::PH_HUNT;
                                if (crc_reg != {crc_hi_reg, crc_lo_reg})
                                begin
                                    res_next   = upr_pkg::RES_LEN_ERR;
                                    state_next = upr_pkg::ST_REPLY_CRC;
                                end
                                else
                                begin
                                    state_next = upr_pkg::ST_SETUP;
                                end
                            end
                            default:
                            begin
                                phase_next = upr_pkg::PH_HUNT;
                            end
                        endcase
                    end
                end
            end

            upr_pkg::ST_READ_WAIT:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.result_kind  = upr_pkg::KIND_READ;
                    out_next.reply_byte   = '0;
                    out_next.reply_last   = 1'b0;
                    out_next.read_data    = oor_reg ? 8'h00 : img_rdata;
                    out_next.image_length = {hp1[16:1], 1'b0};
                    state_next            = upr_pkg::ST_IDLE;
                end
            end

            upr_pkg::ST_SEND_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.result_kind  = upr_pkg::KIND_DONE;
                    out_next.reply_byte   = '0;
                    out_next.reply_last   = 1'b0;
                    out_next.read_data    = '0;
                    out_next.image_length = {hp1[16:1], 1'b0};
                    state_next            = upr_pkg::ST_IDLE;
                end
            end

            upr_pkg::ST_SETUP:
            begin
                idx_next   = '0;
                dec_next   = 1'b0;
                off_next   = '0;
                state_next = upr_pkg::ST_REPLY_CRC;
                if (cmd == upr_pkg::CMD_PING || cmd == upr_pkg::CMD_FW_REV ||
                    cmd == upr_pkg::CMD_HW_ID || cmd == upr_pkg::CMD_COUNT)
                begin
                    res_next = upr_pkg::RES_ACK;
                end
                else if (cmd == upr_pkg::CMD_END)
                begin
                    done_next = 1'b1;
                    res_next  = upr_pkg::RES_ACK;
                end
                else if (cmd != upr_pkg::CMD_BLOCK)
                begin
                    res_next = upr_pkg::RES_UNKNOWN;
                end
                else if (args == 16'd1)
                begin
                    state_next = upr_pkg::ST_KEY_RD;
                end
                else if (args == 16'd0)
                begin
                    state_next = upr_pkg::ST_XF_RD;
                end
                else if (!key_valid_reg)
                begin
                    res_next = upr_pkg::RES_FLASH_ERR;
                end
                else
                begin
                    dec_next   = 1'b1;
                    off_next   = 32'(args - 16'd1) * 32'(BLOCK_BYTES);
                    state_next = upr_pkg::ST_XF_RD;
                end
            end

            upr_pkg::ST_KEY_RD:
            begin
                pkt_re     = 1'b1;
                state_next = upr_pkg::ST_KEY_WR;
            end

            upr_pkg::ST_KEY_WR:
            begin
                key_next[idx_reg[3:0]] = pkt_rdata;
                if (idx_reg[3:0] == 4'd15)
                begin
                    key_valid_next = 1'b1;
                    res_next       = upr_pkg::RES_ACK;
                    state_next     = upr_pkg::ST_REPLY_CRC;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = upr_pkg::ST_KEY_RD;
                end
            end

            upr_pkg::ST_XF_RD:
            begin
                if (16'(idx_reg) >= dlen)
                begin
                    state_next = upr_pkg::ST_REPLY_CRC;
                    if (ovf)
                    begin
                        res_next = upr_pkg::RES_LEN_ERR;
                    end
                    else
                    begin
                        res_next = upr_pkg::RES_ACK;
                        if (sum > 32'(hw_reg))
                        begin
                            hw_next = sum[HW-1:0];
                        end
                    end
                end
                else
                begin
                    pkt_re     = 1'b1;
                    state_next = upr_pkg::ST_XF_WR;
                end
            end

            upr_pkg::ST_XF_WR:
            begin
                if (dec_reg)
                begin
                    pkt_we    = 1'b1;
                    pkt_waddr = idx_reg[PW-1:0];
                    pkt_wdata = nb;
                end
                if (!ovf)
                begin
                    img_we    = 1'b1;
                    img_waddr = IW'(off_reg + 32'(idx_reg));
                    img_wdata = nb;
                end
                idx_next   = idx_reg + CW'(1);
                state_next = upr_pkg::ST_XF_RD;
            end

            upr_pkg::ST_REPLY_CRC:
            begin
                rcrc_next = upr_pkg::crc_byte(rcrc_reg, rbyte);
                if (rpos_reg == 4'd4)
                begin
                    rpos_next  = '0;
                    state_next = upr_pkg::ST_REPLY;
                end
                else
                begin
                    rpos_next = rpos_reg + 4'd1;
                end
            end

            upr_pkg::ST_REPLY:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.result_kind  = upr_pkg::KIND_REPLY;
                    out_next.reply_last   = (rpos_reg == 4'd8);
                    out_next.read_data    = '0;
                    out_next.image_length = {hp1[16:1], 1'b0};
                    case (rpos_reg)
                        4'd0:    out_next.reply_byte = upr_pkg::SYNC_BYTE;
                        4'd1:    out_next.reply_byte = cmd;
                        4'd3:    out_next.reply_byte = res_reg;
                        4'd6:    out_next.reply_byte = rcrc_reg[15:8];
                        4'd7:    out_next.reply_byte = rcrc_reg[7:0];
                        4'd8:    out_next.reply_byte = upr_pkg::FOOTER_BYTE;
                        default: out_next.reply_byte = 8'h00;
                    endcase
                    if (rpos_reg == 4'd8)
                    begin
                        state_next = upr_pkg::ST_IDLE;
                    end
                    else
                    begin
                        rpos_next = rpos_reg + 4'd1;
                    end
                end
            end

            default:
            begin
                state_next = upr_pkg::ST_IDLE;
            end
        endcase
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

[src/upr_ram.sv]
// Byte-wide synchronous RAM with one write port and one registered read port.
module upr_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[dv/update_packet_checker.sv]
// Checker for the update packet receiver: predicts and compares every result transaction.
`timescale 1ns / 1ps

module update_packet_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_ready,
    input  upr_pkg::upr_in_t  item,
    input  logic              result_valid,
    input  logic              result_ready,
    input  upr_pkg::upr_out_t result,
    output int                errors,
    output int                pending
);

    localparam int BB = upr_pkg::BLOCK_BYTES_DEF;
    localparam int IB = upr_pkg::IMAGE_BYTES_DEF;

    upr_pkg::upr_out_t pending_results[$];

    upr_pkg::phase_t phase = upr_pkg::PH_HUNT;
    bit [7:0]        hdr[5];
    int unsigned     pay_cnt = 0;
    bit [15:0]       crc_acc;
    bit [7:0]        crc_hi;
    bit [7:0]        crc_lo;
    bit [7:0]        pkt_mem[BB];
    bit [7:0]        key_mem[16];
    bit              key_ok;
    bit [7:0]        img_mem[IB];
    int unsigned     high_mark = 0;
    bit              finished;
    int              err_count = 0;
    int              pend_count = 0;

    assign errors  = err_count;
    assign pending = pend_count;

    function automatic bit [15:0] crc_step(bit [15:0] crc, bit [7:0] b);
        bit [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ upr_pkg::CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic bit [16:0] rounded_length();
        int unsigned v;
        v = (high_mark + 1) & ~32'd1;
        return v[16:0];
    endfunction

    function automatic void push_result(logic [1:0] kind, bit [7:0] b, bit last, bit [7:0] d);
        upr_pkg::upr_out_t r;
        r.result_kind  = kind;
        r.reply_byte   = b;
        r.reply_last   = last;
        r.read_data    = d;
        r.image_length = rounded_length();
        pending_results.push_back(r);
    endfunction

    function automatic void push_reply(bit [7:0] cmd, bit [7:0] res);
        bit [7:0]  frame[9];
        bit [15:0] c;
        c = '0;
        frame = '{upr_pkg::SYNC_BYTE, cmd, 8'h00, res, 8'h00, 8'h00, 8'h00, 8'h00,
                  upr_pkg::FOOTER_BYTE};
        for (int i = 1; i < 6; i++)
        begin
            c = crc_step(c, frame[i]);
        end
        frame[6] = c[15:8];
        frame[7] = c[7:0];
        for (int i = 0; i < 9; i++)
        begin
            push_result(upr_pkg::KIND_REPLY, frame[i], i == 8, 8'h00);
        end
    endfunction

    function automatic bit [7:0] expanded_key(int unsigned k);
        int unsigned rot;
        int unsigned idx;
        bit [7:0]    b;
        rot = (k >> 4) & 7;
        idx = k & 15;
        b   = key_mem[idx];
        if (rot == 0)
        begin
            return b;
        end
        if (idx < 8)
        begin
            return (b << rot) | (b >> (8 - rot));
        end
        return (b >> rot) | (b << (8 - rot));
    endfunction

    function automatic bit [7:0] run_command(int unsigned dlen);
        bit [7:0]    cmd;
        int unsigned args;
        int unsigned off;
        int unsigned foff;
        bit [7:0]    b;
        bit [7:0]    x;
        cmd  = hdr[0];
        args = {hdr[1], hdr[2]};
        if (cmd == upr_pkg::CMD_PING || cmd == upr_pkg::CMD_FW_REV
            || cmd == upr_pkg::CMD_HW_ID || cmd == upr_pkg::CMD_COUNT)
        begin
            return upr_pkg::RES_ACK;
        end
        if (cmd == upr_pkg::CMD_END)
        begin
            finished = 1'b1;
            return upr_pkg::RES_ACK;
        end
        if (cmd != upr_pkg::CMD_BLOCK)
        begin
            return upr_pkg::RES_UNKNOWN;
        end
        if (args == 1)
        begin
            for (int i = 0; i < 16; i++)
            begin
                key_mem[i] = pkt_mem[i];
            end
            key_ok = 1'b1;
            return upr_pkg::RES_ACK;
        end
        if (args == 0)
        begin
            off = 0;
        end
        else
        begin
            if (!key_ok)
            begin
                return upr_pkg::RES_FLASH_ERR;
            end
            foff = args * BB;
            for (int unsigned i = 0; i < dlen; i++)
            begin
                b = pkt_mem[i];
                if (b != 8'h00 && b != 8'hFF)
                begin
                    x = b ^ expanded_key((foff + i) & 127);
                    if (x != 8'h00 && x != 8'hFF)
                    begin
                        pkt_mem[i] = x;
                    end
                end
            end
            off = (args - 1) * BB;
        end
        if (off + dlen > IB)
        begin
            return upr_pkg::RES_LEN_ERR;
        end
        for (int unsigned i = 0; i < dlen; i++)
        begin
            img_mem[off + i] = pkt_mem[i];
        end
        if (off + dlen > high_mark)
        begin
            high_mark = off + dlen;
        end
        return upr_pkg::RES_ACK;
    endfunction

    function automatic void predict_receiver(upr_pkg::upr_in_t x);
        int unsigned dlen;
        bit [7:0]    cmd;
        bit [7:0]    res;
        dlen = {hdr[3], hdr[4]};
        if (x.opcode == upr_pkg::OP_READ)
        begin
            push_result(upr_pkg::KIND_READ, 8'h00, 1'b0, img_mem[x.read_address]);
            return;
        end
        if ((x.opcode != upr_pkg::OP_RX_BYTE && x.opcode != upr_pkg::OP_TIMEOUT) || finished)
        begin
            return;
        end
        if (x.opcode == upr_pkg::OP_TIMEOUT)
        begin
            finished = 1'b1;
            push_result(upr_pkg::KIND_DONE, 8'h00, 1'b0, 8'h00);
            return;
        end
        case (phase)
            upr_pkg::PH_HUNT:
            begin
                if (x.rx_byte == upr_pkg::SYNC_BYTE)
                begin
                    phase   = upr_pkg::PH_HDR0;
                    crc_acc = '0;
                    pay_cnt = 0;
                end
            end
            upr_pkg::PH_HDR0, upr_pkg::PH_HDR1, upr_pkg::PH_HDR2, upr_pkg::PH_HDR3,
            upr_pkg::PH_HDR4:
            begin
                hdr[phase - upr_pkg::PH_HDR0] = x.rx_byte;
                crc_acc = crc_step(crc_acc, x.rx_byte);
                if (phase != upr_pkg::PH_HDR4)
                begin
                    phase = upr_pkg::phase_t'(phase + 1);
                end
                else
                begin
                    dlen = {hdr[3], hdr[4]};
                    if (dlen > BB)
                    begin
                        phase = upr_pkg::PH_HUNT;
                        push_reply(hdr[0], upr_pkg::RES_LEN_ERR);
                    end
                    else
                    begin
                        pay_cnt = 0;
                        phase   = (dlen == 0) ? upr_pkg::PH_CRCHI : upr_pkg::PH_PAYLOAD;
                    end
                end
            end
            upr_pkg::PH_PAYLOAD:
            begin
                if (pay_cnt < BB)
                begin
                    pkt_mem[pay_cnt] = x.rx_byte;
                end
                crc_acc = crc_step(crc_acc, x.rx_byte);
                pay_cnt++;
                if (pay_cnt >= dlen)
                begin
                    phase = upr_pkg::PH_CRCHI;
                end
            end
            upr_pkg::PH_CRCHI:
            begin
                crc_hi = x.rx_byte;
                phase  = upr_pkg::PH_CRCLO;
            end
            upr_pkg::PH_CRCLO:
            begin
                crc_lo = x.rx_byte;
                phase  = upr_pkg::PH_FOOTER;
            end
            default:
            begin
                phase = upr_pkg::PH_HUNT;
                cmd   = hdr[0];
                if (crc_acc != {crc_hi, crc_lo})
                begin
                    push_reply(cmd, upr_pkg::RES_LEN_ERR);
                end
                else
                begin
                    res = run_command(dlen);
                    push_reply(cmd, res);
                end
            end
        endcase
    endfunction

    always @(posedge clk)
    begin
        upr_pkg::upr_out_t e;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                    begin
                        $display("Unexpected result transaction: %p", result);
                    end
                end
                else
                begin
                    e = pending_results.pop_front();
                    if (result.result_kind !== e.result_kind
                        || result.reply_byte !== e.reply_byte
                        || result.reply_last !== e.reply_last
                        || result.read_data !== e.read_data
                        || result.image_length !== e.image_length)
                    begin
                        err_count++;
                        if (err_count <= 10)
                        begin
                            $display("Mismatch, expected: %p", e);
                            $display("          actual:   %p", result);
                        end
                    end
                end
            end
            if (item_valid && item_ready)
            begin
                predict_receiver(item);
            end
        end
        pend_count = pending_results.size();
    end

endmodule

[dv/tb_update_packet_receiver_top.sv]
// Testbench top for the update packet receiver: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps

module tb_update_packet_receiver_top;

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_ready;
    upr_pkg::upr_in_t  item;
    logic              result_valid;
    logic              result_ready;
    upr_pkg::upr_out_t result;
    int                chk_errors;
    int                chk_pending;

    bit       idle_on = 1'b1;
    int       stall_left = 0;
    int       items_sent;
    bit [7:0] frame_data[$];

    update_packet_receiver_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    update_packet_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .errors       (chk_errors),
        .pending      (chk_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge clk)
    begin
        if (!idle_on)
        begin
            result_ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_ready <= 1'b0;
        end
        else if ($urandom_range(5) == 0)
        begin
            stall_left = $urandom_range(1, 9) - 1;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= 1'b1;
        end
    end

    task automatic send_item(logic [1:0] op, bit [7:0] rx, bit [15:0] addr);
        int gap;
        gap = (idle_on && $urandom_range(3) == 0) ? $urandom_range(1, 9) : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid        <= 1'b1;
        item.opcode       <= op;
        item.rx_byte      <= rx;
        item.read_address <= addr;
        do @(posedge clk); while (!item_ready);
        items_sent++;
    endtask

    task automatic send_byte(bit [7:0] b);
        send_item(upr_pkg::OP_RX_BYTE, b, 16'($urandom));
    endtask

    task automatic send_read(bit [15:0] addr);
        send_item(upr_pkg::OP_READ, 8'($urandom), addr);
    endtask

    function automatic void fill_payload(int n);
        int r;
        frame_data.delete();
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(9);
            frame_data.push_back(r == 0 ? 8'h00 : r == 1 ? 8'hFF : 8'($urandom));
        end
    endfunction

    // Sends one frame around the bytes in frame_data; an oversize length ends after the header.
    task automatic send_frame(bit [7:0] cmd, bit [15:0] arg, bit [15:0] len, bit bad_crc);
        bit [7:0]  hdr[5];
        bit [15:0] c;
        c   = '0;
        hdr = '{cmd, arg[15:8], arg[7:0], len[15:8], len[7:0]};
        send_byte(upr_pkg::SYNC_BYTE);
        foreach (hdr[i])
        begin
            send_byte(hdr[i]);
            c = upr_pkg::crc_byte(c, hdr[i]);
        end
        if (len > upr_pkg::BLOCK_BYTES_DEF)
        begin
            return;
        end
        for (int i = 0; i < len; i++)
        begin
            send_byte(frame_data[i]);
            c = upr_pkg::crc_byte(c, frame_data[i]);
        end
        if (bad_crc)
        begin
            c = c ^ 16'($urandom_range(1, 65535));
        end
        send_byte(c[15:8]);
        send_byte(c[7:0]);
        send_byte(8'($urandom));
    endtask

    task automatic random_frame();
        bit [7:0]  cmd;
        bit [15:0] arg;
        bit [15:0] len;
        bit        bad;
        int        pick;
        pick = $urandom_range(9);
        arg  = 16'($urandom);
        case (pick)
            0: cmd = upr_pkg::CMD_PING;
            1: cmd = upr_pkg::CMD_FW_REV;
            2: cmd = upr_pkg::CMD_HW_ID;
            3: cmd = upr_pkg::CMD_COUNT;
            4: cmd = 8'($urandom);
            default:
            begin
                cmd = upr_pkg::CMD_BLOCK;
                case ($urandom_range(5))
                    0: arg = 16'd0;
                    1: arg = 16'd1;
                    2: arg = 16'($urandom_range(62, 66));
                    3: arg = 16'($urandom);
                    default: arg = 16'($urandom_range(2, 12));
                endcase
            end
        endcase
        pick = $urandom_range(49);
        len  = pick == 0 ? 16'($urandom_range(1025, 65535))
             : pick == 1 ? 16'($urandom_range(25, 96))
             : 16'($urandom_range(0, 24));
        bad = ($urandom_range(6) == 0) || (cmd == upr_pkg::CMD_END);
        fill_payload(len > upr_pkg::BLOCK_BYTES_DEF ? 0 : len);
        send_frame(cmd, arg, len, bad);
    endtask

    initial
    begin
        int target;
        int r;
        rst_n             <= 1'b0;
        item_valid        <= 1'b0;
        item              <= '0;
        items_sent        = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        send_item(upr_pkg::OP_UNUSED, 8'hFF, 16'hFFFF);
        send_read(16'h0000);
        send_read(16'hFFFF);
        frame_data.delete();
        send_frame(upr_pkg::CMD_PING, 16'h0000, 16'd0, 1'b0);
        send_frame(upr_pkg::CMD_FW_REV, 16'hFFFF, 16'd0, 1'b0);
        send_frame(upr_pkg::CMD_HW_ID, 16'h0000, 16'd0, 1'b0);
        send_frame(upr_pkg::CMD_COUNT, 16'h0000, 16'd0, 1'b0);
        fill_payload(2);
        send_frame(8'h77, 16'h1234, 16'd2, 1'b0);
        send_frame(upr_pkg::CMD_PING, 16'h0000, 16'd2, 1'b1);
        send_frame(upr_pkg::CMD_END, 16'h0000, 16'd2, 1'b1);
        send_frame(upr_pkg::CMD_BLOCK, 16'h0002, 16'd1025, 1'b0);
        send_frame(upr_pkg::CMD_BLOCK, 16'h0002, 16'hFFFF, 1'b0);
        fill_payload(3);
        send_frame(upr_pkg::CMD_BLOCK, 16'h0002, 16'd3, 1'b0);
        fill_payload(7);
        send_frame(upr_pkg::CMD_BLOCK, 16'h0000, 16'd7, 1'b0);
        send_read(16'd6);
        fill_payload(4);
        send_frame(upr_pkg::CMD_BLOCK, 16'h0001, 16'd4, 1'b0);
        fill_payload(16);
        send_frame(upr_pkg::CMD_BLOCK, 16'h0002, 16'd16, 1'b0);
        fill_payload(16);
        send_frame(upr_pkg::CMD_BLOCK, 16'd64, 16'd16, 1'b0);
        fill_payload(4);
        send_frame(upr_pkg::CMD_BLOCK, 16'd65, 16'd4, 1'b0);
        fill_payload(1);
        send_frame(upr_pkg::CMD_BLOCK, 16'hFFFF, 16'd1, 1'b0);
        send_read(16'd1024);
        send_read(16'd64512);
        send_read(16'hFFFF);

        item_valid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0) @(posedge clk);

        target = 430;
        while (items_sent < target)
        begin
            if (target - items_sent < 60)
            begin
                idle_on = 1'b0;
            end
            r = $urandom_range(19);
            if (r < 14)
            begin
                random_frame();
            end
            else if (r < 17)
            begin
                send_read($urandom_range(1) ? 16'($urandom) : 16'($urandom_range(0, 4095)));
            end
            else if (r < 18)
            begin
                send_item(upr_pkg::OP_UNUSED, 8'($urandom), 16'($urandom));
            end
            else
            begin
                r = $urandom_range(254);
                send_byte(r >= upr_pkg::SYNC_BYTE ? 8'(r + 1) : 8'(r));
            end
        end

        if ($urandom_range(1))
        begin
            frame_data.delete();
            send_frame(upr_pkg::CMD_END, 16'h0000, 16'd0, 1'b0);
        end
        else
        begin
            send_byte(upr_pkg::SYNC_BYTE);
            send_byte(upr_pkg::CMD_PING);
            send_item(upr_pkg::OP_TIMEOUT, 8'h00, 16'h0000);
        end
        frame_data.delete();
        send_frame(upr_pkg::CMD_PING, 16'h0000, 16'd0, 1'b0);
        send_item(upr_pkg::OP_TIMEOUT, 8'hFF, 16'hFFFF);
        send_read(16'd3);
        send_read(16'($urandom));
        item_valid <= 1'b0;

        @(posedge clk);
        while (chk_pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (chk_errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
